/* design/nwpe_pkg.sv */
// nwpe_pkg: shared constants, parity masks and the queue entry type
// for the navigation word parity encoder; no dependencies
`default_nettype none

package nwpe_pkg;

    // fixed frame structure
    localparam int WORDS_PER_SUBFRAME  = 10;
    localparam int SUBFRAMES_PER_FRAME = 5;

    // default depth of the queue between front and back
    localparam int FIFO_DEPTH = 4;

    // field widths
    localparam int DATA_W = 24;
    localparam int TOW_W  = 17;
    localparam int SF_W   = 3;
    localparam int WEEK_W = 10;
    localparam int WORD_W = 30;
    localparam int IDX_W  = 4;

    // word positions within a subframe
    localparam logic [IDX_W-1:0] HOW_WORD  = IDX_W'(1);
    localparam logic [IDX_W-1:0] WEEK_WORD = IDX_W'(2);
    localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(WORDS_PER_SUBFRAME - 1);

    // subframe numbering runs first..last
    localparam logic [SF_W-1:0] FIRST_SUBFRAME = SF_W'(1);
    localparam logic [SF_W-1:0] LAST_SUBFRAME  = SF_W'(SUBFRAMES_PER_FRAME);

    // parity equations for D25..D30 over the data field D1..D24
    localparam logic [WORD_W-1:0] PARITY_MASK [6] = '{
        30'h3B1F3480, 30'h1D8F9A40, 30'h2EC7CD00,
        30'h1763E680, 30'h2BB1F340, 30'h0B7A89C0
    };

    // data field D1..D24 inside a transmitted word
    localparam logic [WORD_W-1:0] DATA_FIELD = 30'h3FFFFFC0;

    // one classified word waiting for encoding
    typedef struct packed {
        logic [DATA_W-1:0] data;        // d1..d24 with counts inserted
        logic [IDX_W-1:0]  idx;         // word position in subframe
        logic              restart;     // clear the parity chain first
        logic              fix_parity;  // force D29 and D30 to zero
        logic              last;        // last word of its subframe
    } t_work;

endpackage

`default_nettype wire

/* design/nav_word_parity_encoder.sv */
// nav_word_parity_encoder: top level joining front, queue and back
// uses nwpe_pkg, nwpe_front, nwpe_fifo, nwpe_back
//
//  channel   | direction | handshake                      | payload
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | tdata, tuser (restart)
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata, tlast (subframe end)
//  cfg       | in        | i_cfg_wr_en                    | i_cfg_wr_data (week number)
//
// one word in and one word out per cycle when neither side stalls
// a word passes the queue write, then the parity stage into the output register
// the queue holds FIFO_DEPTH words; with the output stalled, tready drops once it is full
// i_rst_n is synchronous; it clears counters, chain bits, queue and output valid
`default_nettype none

module nav_word_parity_encoder #(
    parameter int FIFO_DEPTH = nwpe_pkg::FIFO_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // source_bits[23:0], tow_start[40:24], start_subframe[43:41], zero[47:44]
    input  wire logic [47:0]                 s_axis_tdata,
    // restart[0]
    input  wire logic                        s_axis_tuser,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // encoded_word[29:0], word_index[33:30], zero[39:34]
    output logic [39:0]                      m_axis_tdata,
    output logic                             m_axis_tlast,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [nwpe_pkg::WEEK_W-1:0] i_cfg_wr_data
);

    nwpe_pkg::t_work              work, head;
    logic                         accept;
    logic                         not_full, not_empty, pop;
    logic [nwpe_pkg::WORD_W-1:0]  out_word;
    logic [nwpe_pkg::IDX_W-1:0]   out_idx;

    assign s_axis_tready = not_full;
    assign accept        = s_axis_tvalid && not_full;

    // front: counting and insertion
    nwpe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_accept         (accept),
        .i_source_bits    (s_axis_tdata[23:0]),
        .i_restart        (s_axis_tuser),
        .i_tow_start      (s_axis_tdata[40:24]),
        .i_start_subframe (s_axis_tdata[43:41]),
        .o_work           (work)
    );

    // queue between the halves
    nwpe_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_wdata     (work),
        .i_pop       (pop),
        .o_head      (head),
        .o_not_empty (not_empty),
        .o_not_full  (not_full)
    );

    // back: parity encoding and output register
    nwpe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (not_empty),
        .i_tready     (m_axis_tready),
        .o_pop        (pop),
        .o_tvalid     (m_axis_tvalid),
        .o_word       (out_word),
        .o_idx        (out_idx),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, out_idx, out_word};

`ifndef NO_ASSERTIONS
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output word changed while stalled");
`endif

endmodule

`default_nettype wire

/* design/nwpe_front.sv */
// nwpe_front: word, subframe and time-of-week counting, count insertion
// and week number register; uses nwpe_pkg
`default_nettype none

module nwpe_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [nwpe_pkg::WEEK_W-1:0] i_cfg_wr_data,
    input  wire logic                        i_accept,
    input  wire logic [nwpe_pkg::DATA_W-1:0] i_source_bits,
    input  wire logic                        i_restart,
    input  wire logic [nwpe_pkg::TOW_W-1:0]  i_tow_start,
    input  wire logic [nwpe_pkg::SF_W-1:0]   i_start_subframe,
    output nwpe_pkg::t_work                  o_work
);

    logic [nwpe_pkg::WEEK_W-1:0] r_week;
    logic [nwpe_pkg::IDX_W-1:0]  r_word_count, n_word_count;
    logic [nwpe_pkg::SF_W-1:0]   r_subframe, n_subframe;
    logic [nwpe_pkg::TOW_W-1:0]  r_tow, n_tow;

    logic [nwpe_pkg::IDX_W-1:0]  cur_word;
    logic [nwpe_pkg::SF_W-1:0]   cur_subframe;
    logic [nwpe_pkg::TOW_W-1:0]  cur_tow;
    logic                        sf_in_range;
    logic [nwpe_pkg::DATA_W-1:0] data;
    logic                        last;

    // counts in force for this word, restart loads them first
    always_comb begin
        sf_in_range  = (i_start_subframe >= nwpe_pkg::FIRST_SUBFRAME) &&
                       (i_start_subframe <= nwpe_pkg::LAST_SUBFRAME);
        cur_word     = i_restart ? '0 : r_word_count;
        cur_subframe = i_restart ? (sf_in_range ? i_start_subframe : nwpe_pkg::FIRST_SUBFRAME)
                                 : r_subframe;
        cur_tow      = i_restart ? i_tow_start : r_tow;
    end

    // or the time of week into the HOW and the week number into subframe one
    always_comb begin
        data = i_source_bits;
        if (cur_word == nwpe_pkg::HOW_WORD) begin
            data = data | {cur_tow, 7'b0};
        end
        if ((cur_subframe == nwpe_pkg::FIRST_SUBFRAME) &&
            (cur_word == nwpe_pkg::WEEK_WORD)) begin
            data = data | {r_week, 14'b0};
        end
        last = (cur_word >= nwpe_pkg::LAST_WORD);
    end

    // classified word for the queue
    always_comb begin
        o_work.data       = data;
        o_work.idx        = cur_word;
        o_work.restart    = i_restart;
        o_work.fix_parity = (cur_word == nwpe_pkg::HOW_WORD) || last;
        o_work.last       = last;
    end

    // counter advance after this word
    always_comb begin
        n_word_count = cur_word + 1'b1;
        n_subframe   = cur_subframe;
        n_tow        = cur_tow;
        if (last) begin
            n_word_count = '0;
            n_subframe   = (cur_subframe >= nwpe_pkg::LAST_SUBFRAME) ?
                           nwpe_pkg::FIRST_SUBFRAME : cur_subframe + 1'b1;
            n_tow        = cur_tow + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_week       <= '0;
            r_word_count <= '0;
            r_subframe   <= nwpe_pkg::FIRST_SUBFRAME;
            r_tow        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_week <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_word_count <= n_word_count;
                r_subframe   <= n_subframe;
                r_tow        <= n_tow;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_word_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_count <= nwpe_pkg::LAST_WORD)
        else $error("word count beyond subframe length");

    a_subframe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_subframe >= nwpe_pkg::FIRST_SUBFRAME) && (r_subframe <= nwpe_pkg::LAST_SUBFRAME))
        else $error("subframe count out of range");
`endif

endmodule

`default_nettype wire

/* design/nwpe_fifo.sv */
// nwpe_fifo: short queue of classified words between front and back
// uses nwpe_pkg for the entry type
`default_nettype none

module nwpe_fifo #(
    parameter int DEPTH = nwpe_pkg::FIFO_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire nwpe_pkg::t_work i_wdata,
    input  wire logic   i_pop,
    output nwpe_pkg::t_work o_head,
    output logic        o_not_empty,
    output logic        o_not_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    nwpe_pkg::t_work   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_head      = r_mem[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_not_full  = (r_count != CNT_W'(DEPTH));

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_not_full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

/* design/nwpe_back.sv */
// nwpe_back: parity chain, d23/d24 solving and registered output word
// uses nwpe_pkg for masks and the entry type
`default_nettype none

module nwpe_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire nwpe_pkg::t_work             i_head,
    input  wire logic                        i_head_valid,
    input  wire logic                        i_tready,
    output logic                             o_pop,
    output logic                             o_tvalid,
    output logic [nwpe_pkg::WORD_W-1:0]      o_word,
    output logic [nwpe_pkg::IDX_W-1:0]       o_idx,
    output logic                             o_last
);

    logic                         r_prev29, r_prev30;
    logic                         r_valid;
    logic [nwpe_pkg::WORD_W-1:0]  r_word, n_word;
    logic [nwpe_pkg::IDX_W-1:0]   r_idx;
    logic                         r_last;
    logic                         c29, c30;

    // encode one word against the chain bits of the previous one
    function automatic logic [nwpe_pkg::WORD_W-1:0] f_encode(
        input logic [nwpe_pkg::DATA_W-1:0] data,
        input logic                        b29,
        input logic                        b30,
        input logic                        fix_parity
    );
        logic [nwpe_pkg::WORD_W-1:0] d;
        logic [nwpe_pkg::WORD_W-1:0] w;
        d = {data, 6'b0};
        if (fix_parity) begin
            if ((b30 ^ (^(nwpe_pkg::PARITY_MASK[4] & d))) != 1'b0) begin
                d[6] = ~d[6];
            end
            if ((b29 ^ (^(nwpe_pkg::PARITY_MASK[5] & d))) != 1'b0) begin
                d[7] = ~d[7];
            end
        end
        w    = b30 ? (d ^ nwpe_pkg::DATA_FIELD) : d;
        w[5] = b29 ^ (^(nwpe_pkg::PARITY_MASK[0] & d));
        w[4] = b30 ^ (^(nwpe_pkg::PARITY_MASK[1] & d));
        w[3] = b29 ^ (^(nwpe_pkg::PARITY_MASK[2] & d));
        w[2] = b30 ^ (^(nwpe_pkg::PARITY_MASK[3] & d));
        w[1] = b30 ^ (^(nwpe_pkg::PARITY_MASK[4] & d));
        w[0] = b29 ^ (^(nwpe_pkg::PARITY_MASK[5] & d));
        return w;
    endfunction

    // take the next word whenever the output register is free or draining
    assign o_pop = i_head_valid && (!r_valid || i_tready);

    // chain bits, cleared by a restart word
    always_comb begin
        c29    = i_head.restart ? 1'b0 : r_prev29;
        c30    = i_head.restart ? 1'b0 : r_prev30;
        n_word = f_encode(i_head.data, c29, c30, i_head.fix_parity);
    end

    // control: valid flag and chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_prev29 <= 1'b0;
            r_prev30 <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid  <= 1'b1;
                r_prev29 <= n_word[1];
                r_prev30 <= n_word[0];
            end else if (i_tready) begin
                r_valid  <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= n_word;
            r_idx  <= i_head.idx;
            r_last <= i_head.last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_word   = r_word;
    assign o_idx    = r_idx;
    assign o_last   = r_last;

`ifndef NO_ASSERTIONS
    a_solved_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.fix_parity) |=> (r_word[1:0] == 2'b00))
        else $error("solved word left nonzero D29/D30");
`endif

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// tb_top: self-checking bench for the navigation word parity encoder
// needs nwpe_pkg and nav_word_parity_encoder; predicts each encoded word and checks the stream
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int HOLD_CYCLES    = 50;
    localparam int HOLD_SPACING   = 500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PASS = 305;
    localparam logic [nwpe_pkg::WEEK_W-1:0] WEEK_MAX = '1;
    localparam logic [nwpe_pkg::TOW_W-1:0]  TOW_MAX  = '1;
    localparam logic [nwpe_pkg::DATA_W-1:0] ONES     = '1;

    // one input word as the sender sees it
    typedef struct packed {
        logic [nwpe_pkg::DATA_W-1:0] source;
        logic                        restart;
        logic [nwpe_pkg::TOW_W-1:0]  tow;
        logic [nwpe_pkg::SF_W-1:0]   subframe;
    } t_nav_item;

    // one transmitted word with its position
    typedef struct packed {
        logic [nwpe_pkg::WORD_W-1:0] code;
        logic [nwpe_pkg::IDX_W-1:0]  idx;
        logic                        last;
    } t_coded_word;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic [47:0]                 s_axis_tdata = '0;
    logic                        s_axis_tuser = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [39:0]                 m_axis_tdata;
    logic                        m_axis_tlast;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic                        i_cfg_wr_en = 1'b0;
    logic [nwpe_pkg::WEEK_W-1:0] i_cfg_wr_data = '0;

    nav_word_parity_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // words waiting to be sent and encoded words still to arrive
    t_nav_item   pending_items[$];
    t_coded_word expected_words[$];

    // predicted encoder state
    logic                        chain29 = 1'b0;
    logic                        chain30 = 1'b0;
    logic [nwpe_pkg::IDX_W-1:0]  word_no = '0;
    logic [nwpe_pkg::SF_W-1:0]   subframe_no = nwpe_pkg::FIRST_SUBFRAME;
    logic [nwpe_pkg::TOW_W-1:0]  tow_no = '0;
    logic [nwpe_pkg::WEEK_W-1:0] week_reg = '0;

    int mismatches = 0;
    int words_in = 0;
    int hold_left = 0;
    int next_hold_at = 100;

    // sender and receiver pacing
    t_nav_item tx_word;
    int        tx_gap = 0;
    bit        tx_calm = 1'b0;
    int        tx_count = 0;
    int        rx_stall = 0;
    bit        rx_calm = 1'b0;
    int        rx_count = 0;
    int        quiet_cycles = 0;

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // parity encoding of one word, advancing the predicted counters
    task automatic encode_nav_word(input t_nav_item it);
        logic [nwpe_pkg::DATA_W-1:0] data;
        logic [nwpe_pkg::WORD_W-1:0] d;
        logic [nwpe_pkg::WORD_W-1:0] w;
        logic                        c29;
        logic                        c30;
        t_coded_word                 r;
        if (it.restart) begin
            chain29 = 1'b0;
            chain30 = 1'b0;
            word_no = '0;
            subframe_no = (it.subframe >= nwpe_pkg::FIRST_SUBFRAME &&
                           it.subframe <= nwpe_pkg::LAST_SUBFRAME)
                        ? it.subframe : nwpe_pkg::FIRST_SUBFRAME;
            tow_no = it.tow;
        end
        // counts are ORed in, never replacing set bits
        data = it.source;
        if (word_no == nwpe_pkg::HOW_WORD)
            data = data | {tow_no, 7'b0};
        if (subframe_no == nwpe_pkg::FIRST_SUBFRAME && word_no == nwpe_pkg::WEEK_WORD)
            data = data | {week_reg, 14'b0};
        d = {data, 6'b0};
        c29 = chain29;
        c30 = chain30;
        // solve d24 then d23 so that D29 and D30 come out zero
        if (word_no == nwpe_pkg::HOW_WORD || word_no == nwpe_pkg::LAST_WORD) begin
            if (c30 ^ (^(nwpe_pkg::PARITY_MASK[4] & d)))
                d[6] = ~d[6];
            if (c29 ^ (^(nwpe_pkg::PARITY_MASK[5] & d)))
                d[7] = ~d[7];
        end
        w = c30 ? (d ^ nwpe_pkg::DATA_FIELD) : d;
        w[5] = c29 ^ (^(nwpe_pkg::PARITY_MASK[0] & d));
        w[4] = c30 ^ (^(nwpe_pkg::PARITY_MASK[1] & d));
        w[3] = c29 ^ (^(nwpe_pkg::PARITY_MASK[2] & d));
        w[2] = c30 ^ (^(nwpe_pkg::PARITY_MASK[3] & d));
        w[1] = c30 ^ (^(nwpe_pkg::PARITY_MASK[4] & d));
        w[0] = c29 ^ (^(nwpe_pkg::PARITY_MASK[5] & d));
        r.code = w;
        r.idx = word_no;
        r.last = (word_no >= nwpe_pkg::LAST_WORD);
        expected_words.push_back(r);
        chain29 = w[1];
        chain30 = w[0];
        // step word, subframe and time-of-week counts
        if (word_no >= nwpe_pkg::LAST_WORD) begin
            word_no = '0;
            subframe_no = (subframe_no >= nwpe_pkg::LAST_SUBFRAME)
                        ? nwpe_pkg::FIRST_SUBFRAME : subframe_no + 1'b1;
            tow_no = tow_no + 1'b1;
        end else begin
            word_no = word_no + 1'b1;
        end
    endtask

    // sender: offers queued words, predicts each one on acceptance
    always @(posedge i_clk) begin : tx_side
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                encode_nav_word(tx_word);
                words_in <= words_in + 1;
                tx_count++;
                if (tx_count % 64 == 0)
                    tx_calm = ($urandom_range(0, 2) == 0);
                tx_gap = draw_wait(tx_calm);
            end else if (!s_axis_tvalid && tx_gap > 0) begin
                tx_gap--;
            end
            // a word still waiting for tready stays on the bus
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (tx_gap == 0 && pending_items.size() != 0) begin
                    tx_word = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {4'b0, tx_word.subframe, tx_word.tow, tx_word.source};
                    s_axis_tuser <= tx_word.restart;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the internal queue fills and the input stalls
    always @(posedge i_clk) begin : hold_off
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (words_in >= next_hold_at) begin
            hold_left <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + HOLD_SPACING;
        end
    end

    // receiver: checks every accepted word against the oldest prediction
    always @(posedge i_clk) begin : rx_side
        t_coded_word got;
        t_coded_word want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.code = m_axis_tdata[nwpe_pkg::WORD_W-1:0];
                got.idx = m_axis_tdata[nwpe_pkg::WORD_W+nwpe_pkg::IDX_W-1:nwpe_pkg::WORD_W];
                got.last = m_axis_tlast;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: code %h idx %0d last %b",
                                 got.code, got.idx, got.last);
                end else begin
                    want = expected_words.pop_front();
                    if (got.code !== want.code || got.idx !== want.idx
                        || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected code %h idx %0d last %b, ",
                                      "got code %h idx %0d last %b"},
                                     want.code, want.idx, want.last,
                                     got.code, got.idx, got.last);
                    end
                end
                rx_count++;
                if (rx_count % 64 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                rx_stall = draw_wait(rx_calm);
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            m_axis_tready <= (rx_stall == 0) && (hold_left == 0);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_item(input logic [nwpe_pkg::DATA_W-1:0] source,
                              input logic restart,
                              input logic [nwpe_pkg::TOW_W-1:0] tow,
                              input logic [nwpe_pkg::SF_W-1:0] subframe);
        t_nav_item it;
        it.source = source;
        it.restart = restart;
        it.tow = tow;
        it.subframe = subframe;
        pending_items.push_back(it);
    endtask

    // mostly running frames with random content, occasional restarts anywhere
    task automatic queue_random(input int count);
        logic [nwpe_pkg::DATA_W-1:0] source;
        logic [nwpe_pkg::SF_W-1:0]   subframe;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 15))
                0:       source = '0;
                1:       source = ONES;
                default: source = nwpe_pkg::DATA_W'($urandom);
            endcase
            subframe = ($urandom_range(0, 9) == 0) ? nwpe_pkg::SF_W'($urandom_range(0, 7))
                                                   : nwpe_pkg::SF_W'($urandom_range(1, 5));
            queue_item(source, $urandom_range(0, 59) == 0, nwpe_pkg::TOW_W'($urandom),
                       subframe);
        end
    endtask

    // wait for the pipeline to drain completely
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_week(input logic [nwpe_pkg::WEEK_W-1:0] value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        week_reg = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_week(WEEK_MAX);
        // full subframe 1 from the largest time of week, extremes of the data
        queue_item(ONES, 1'b1, TOW_MAX, 3'd1);
        queue_item('0, 1'b0, '0, 3'd0);
        queue_item('0, 1'b0, '0, 3'd0);
        queue_item(ONES, 1'b0, TOW_MAX, 3'd7);
        queue_item('0, 1'b0, '0, 3'd0);
        queue_item(ONES, 1'b0, TOW_MAX, 3'd7);
        queue_item(nwpe_pkg::DATA_W'($urandom), 1'b0, '0, 3'd0);
        queue_item(nwpe_pkg::DATA_W'($urandom), 1'b0, '0, 3'd0);
        queue_item(ONES, 1'b0, '0, 3'd0);
        queue_item(ONES, 1'b0, '0, 3'd0);
        // subframe 2 with the time of week wrapped to zero
        queue_item(ONES, 1'b0, nwpe_pkg::TOW_W'($urandom), nwpe_pkg::SF_W'($urandom));
        // restarts with out-of-range subframe numbers
        queue_item(24'hAAAAAA, 1'b1, '0, 3'd0);
        queue_item(24'h555555, 1'b1, 17'h15555, 3'd6);
        queue_item(24'h800001, 1'b1, 17'h0AAAA, 3'd7);
        // subframe 5 run through to the frame wrap back to subframe 1
        queue_item(nwpe_pkg::DATA_W'($urandom), 1'b1, 17'h1FFFE, 3'd5);
        for (int k = 0; k < 10; k++)
            queue_item(nwpe_pkg::DATA_W'($urandom), 1'b0, nwpe_pkg::TOW_W'($urandom),
                       nwpe_pkg::SF_W'($urandom));

        write_week('0);
        queue_random(ITEMS_PER_PASS);
        write_week(10'h2AA);
        queue_random(ITEMS_PER_PASS);
        write_week(nwpe_pkg::WEEK_W'($urandom));
        queue_random(ITEMS_PER_PASS);
        write_week(10'h155);
        queue_random(ITEMS_PER_PASS);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
design/nwpe_pkg.sv
design/nwpe_front.sv
design/nwpe_fifo.sv
design/nwpe_back.sv
design/nav_word_parity_encoder.sv
sim/tb_top.sv
